// ===== sv/background_diff_morph_mask_top_macros.svh =====
// assertion macros used by the mask pipeline cell module
// expects clk and rst in the scope where a macro is used
`ifndef BACKGROUND_DIFF_MORPH_MASK_TOP_MACROS_SVH
`define BACKGROUND_DIFF_MORPH_MASK_TOP_MACROS_SVH

// property checked on every clock outside reset
`define BDM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// condition in one cycle implies result in the next
`define BDM_ASSERT_NEXT(name, cond, res, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (res)) \
    else $error(msg);

`endif

// ===== sv/bdm_pkg.sv =====
// shared types, register codes and defaults for the background difference mask
// no dependencies
`default_nettype none

package bdm_pkg;

  localparam int MAX_WIDTH_DEF   = 2048;
  localparam int MAX_HEIGHT_DEF  = 4096;
  localparam int KERNEL_SIZE_DEF = 7;

  localparam int ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_THRESH = 3'd0,
    REG_CENTER = 3'd1,
    REG_MARGIN = 3'd2,
    REG_WIDTH  = 3'd3,
    REG_HEIGHT = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic       op;
    logic [7:0] gray_pixel;
    logic [7:0] background_pixel;
  } pix_t;

  typedef struct packed {
    logic        foreground;
    logic [10:0] mask_col;
    logic [11:0] mask_row;
    logic        frame_last;
  } mask_t;

  typedef struct packed {
    logic [7:0]         diff_threshold;
    logic signed [12:0] band_center_row;
    logic [11:0]        band_margin_rows;
    logic [11:0]        frame_width;
    logic [12:0]        frame_height;
  } cfg_t;

  // one tick handed between cells
  typedef struct packed {
    logic strobe;
    logic act;
    logic bit_v;
    logic last;
  } ctl_t;

endpackage

`default_nettype wire

// ===== sv/bdm_front.sv =====
// front end: frame tracking, threshold and row band, first cell input
// depends on bdm_pkg
`default_nettype none

module bdm_front import bdm_pkg::*; #(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF,
  parameter int KERNEL_SIZE = KERNEL_SIZE_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              en,
  input  wire logic                              pix_take,
  input  wire pix_t                              pix,
  input  wire cfg_t                              cfg,
  output ctl_t                                   ctl,
  output logic [$clog2(MAX_WIDTH+1)-1:0]         w,
  output logic [$clog2(MAX_HEIGHT+1)-1:0]        h
);

  localparam int R  = KERNEL_SIZE / 2;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 4 * R + 2);
  localparam int TW = $clog2(MAX_WIDTH * (MAX_HEIGHT + 4 * R) + 4 * R + 1);

  logic          active;
  logic [TW-1:0] tick;
  logic [TW-1:0] lt;
  logic [WW-1:0] lw;
  logic [HW-1:0] lh;
  logic [RW-1:0] frow;
  logic [CW-1:0] fcol;

  logic [WW-1:0] ws;
  logic [HW-1:0] hs;
  logic [TW-1:0] ts;
  logic [WW-1:0] cur_w;
  logic [HW-1:0] cur_h;
  logic [TW-1:0] cur_t;
  logic          take;
  logic          last;
  logic [7:0]    diff;
  logic          fg;
  logic          band_on;
  logic signed [15:0] c16, m16, r16;
  logic          bit_v;

  always_comb begin
    if (cfg.frame_width == '0) begin
      ws = WW'(1);
    end else if (32'(cfg.frame_width) > MAX_WIDTH) begin
      ws = WW'(MAX_WIDTH);
    end else begin
      ws = WW'(cfg.frame_width);
    end
    if (cfg.frame_height == '0) begin
      hs = HW'(1);
    end else if (32'(cfg.frame_height) > MAX_HEIGHT) begin
      hs = HW'(MAX_HEIGHT);
    end else begin
      hs = HW'(cfg.frame_height);
    end
    ts = TW'(32'(ws) * (32'(hs) + 32'(4 * R)) + 32'(4 * R));
    cur_w = active ? lw : ws;
    cur_h = active ? lh : hs;
    cur_t = active ? lt : ts;
    take  = pix_take && !(pix.op && (32'(frow) < 32'(cur_h)));
    last  = (tick == cur_t - TW'(1));
    diff  = (pix.gray_pixel > pix.background_pixel) ?
            pix.gray_pixel - pix.background_pixel :
            pix.background_pixel - pix.gray_pixel;
    fg    = diff > cfg.diff_threshold;
    c16   = 16'(cfg.band_center_row);
    m16   = $signed({4'b0000, cfg.band_margin_rows});
    r16   = $signed(16'(frow));
    band_on = !cfg.band_center_row[12] && (cfg.band_margin_rows != '0);
    bit_v = fg && !(band_on && ((r16 < c16 - m16) || (r16 >= c16 + m16)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      tick   <= '0;
      frow   <= '0;
      fcol   <= '0;
      ctl    <= '0;
    end else if (en) begin
      ctl.strobe <= take;
      ctl.act    <= 1'b1;
      ctl.bit_v  <= bit_v;
      ctl.last   <= last;
      if (take) begin
        if (last) begin
          active <= 1'b0;
          tick   <= '0;
          frow   <= '0;
          fcol   <= '0;
        end else begin
          active <= 1'b1;
          tick   <= tick + TW'(1);
          if (32'(fcol) + 1 == 32'(cur_w)) begin
            fcol <= '0;
            frow <= frow + RW'(1);
          end else begin
            fcol <= fcol + CW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && !active) begin
      lw <= ws;
      lh <= hs;
      lt <= ts;
    end
    if (en) begin
      w <= cur_w;
      h <= cur_h;
    end
  end

endmodule

`default_nettype wire

// ===== sv/bdm_cell.sv =====
// one morphology cell: line store, column reduce and row window
// depends on bdm_pkg and the assertion macro header
`default_nettype none
`include "background_diff_morph_mask_top_macros.svh"

module bdm_cell import bdm_pkg::*; #(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF,
  parameter int KERNEL_SIZE = KERNEL_SIZE_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              en,
  input  wire logic                              dilate,
  input  wire ctl_t                              in_ctl,
  input  wire logic [$clog2(MAX_WIDTH+1)-1:0]    in_w,
  input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]   in_h,
  output ctl_t                                   out_ctl,
  output logic [$clog2(MAX_WIDTH+1)-1:0]         out_w,
  output logic [$clog2(MAX_HEIGHT+1)-1:0]        out_h
);

  localparam int K  = KERNEL_SIZE;
  localparam int R  = KERNEL_SIZE / 2;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 4 * R + 2);
  localparam int DW = $clog2(R * MAX_WIDTH + R + 1);

  logic [K-2:0]  mem [MAX_WIDTH];
  logic [K-2:0]  q;
  logic [K-2:0]  fwd;
  logic          hit;

  logic [RW-1:0] irow;
  logic [CW-1:0] icol;
  logic [DW-1:0] wcnt;
  logic [DW-1:0] d_lim;
  logic          go;

  ctl_t          sb_ctl;
  logic          sb_go;
  logic [WW-1:0] sb_w;
  logic [HW-1:0] sb_h;
  logic [RW-1:0] sb_row;
  logic [CW-1:0] sb_col;

  logic [K-1:0]  hw;
  logic [K-1:0]  hw_next;
  logic [CW-1:0] ocol;

  logic          neutral;
  logic [K-2:0]  v;
  logic          nb;
  logic          colres;
  logic          hres;
  logic [K-2:0]  wdata;
  logic          sb_wr;
  logic          term;

  always_comb begin
    d_lim = DW'(32'(in_w) * R + R);
    go    = (wcnt == d_lim);
  end

  always_comb begin
    neutral = !dilate;
    v       = hit ? fwd : q;
    nb      = (32'(sb_row) >= 32'(sb_h)) ? neutral : sb_ctl.bit_v;
    colres  = nb;
    for (int k = 1; k < K; k++) begin
      term = (32'(sb_row) >= k) ? v[k-1] : neutral;
      colres = dilate ? (colres | term) : (colres & term);
    end
    wdata   = {v[K-3:0], nb};
    sb_wr   = sb_ctl.strobe && sb_ctl.act;
    hw_next = sb_wr ? {hw[K-2:0], colres} : hw;
    hres    = neutral;
    for (int k = 0; k < K; k++) begin
      if (k > R) begin
        term = (32'(ocol) >= k - R) ? hw_next[k] : neutral;
      end else if (k < R) begin
        term = (32'(ocol) + (R - k) < 32'(sb_w)) ? hw_next[k] : neutral;
      end else begin
        term = hw_next[k];
      end
      hres = dilate ? (hres | term) : (hres & term);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (sb_wr) begin
        mem[sb_col] <= wdata;
      end
      q      <= mem[icol];
      fwd    <= wdata;
      sb_w   <= in_w;
      sb_h   <= in_h;
      sb_row <= irow;
      sb_col <= icol;
      sb_go  <= go;
      out_w  <= sb_w;
      out_h  <= sb_h;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      irow    <= '0;
      icol    <= '0;
      wcnt    <= '0;
      hit     <= 1'b0;
      sb_ctl  <= '0;
      hw      <= '0;
      ocol    <= '0;
      out_ctl <= '0;
    end else if (en) begin
      hit    <= sb_wr && (sb_col == icol);
      sb_ctl <= in_ctl;
      if (in_ctl.strobe && in_ctl.last) begin
        irow <= '0;
        icol <= '0;
        wcnt <= '0;
      end else if (in_ctl.strobe && in_ctl.act) begin
        if (!go) begin
          wcnt <= wcnt + DW'(1);
        end
        if (32'(icol) + 1 == 32'(in_w)) begin
          icol <= '0;
          irow <= irow + RW'(1);
        end else begin
          icol <= icol + CW'(1);
        end
      end
      hw <= hw_next;
      out_ctl.strobe <= sb_ctl.strobe;
      out_ctl.act    <= sb_wr && sb_go;
      out_ctl.bit_v  <= hres;
      out_ctl.last   <= sb_ctl.last;
      if (sb_ctl.strobe && sb_ctl.last) begin
        ocol <= '0;
      end else if (sb_wr && sb_go) begin
        if (32'(ocol) + 1 == 32'(sb_w)) begin
          ocol <= '0;
        end else begin
          ocol <= ocol + CW'(1);
        end
      end
    end
  end

  `BDM_ASSERT(a_act_needs_strobe, out_ctl.act |-> out_ctl.strobe, "active tick without strobe")
  `BDM_ASSERT(a_col_in_row, sb_wr |-> (32'(sb_col) < 32'(sb_w)), "column beyond row width")
  `BDM_ASSERT_NEXT(a_last_clears, en && sb_ctl.strobe && sb_ctl.last, ocol == '0,
    "output column not cleared at frame end")

endmodule

`default_nettype wire

// ===== sv/background_diff_morph_mask_top.sv =====
// An accepted item passes the front stage register, then two registers per cell (line store read,
// then column and row reduce), before its mask transaction. Throughput: one item per cycle;
// the first 4*(R*W+R) items of a frame give no mask pixel, R = KERNEL_SIZE/2.
// The whole chain advances together and holds while a mask transaction waits.
// Reset: synchronous, clears frame counters and tick strobes; registers take their defaults,
// line stores are masked by the row counters and need no clearing pass.
`default_nettype none

module background_diff_morph_mask_top import bdm_pkg::*; #(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF,
  parameter int KERNEL_SIZE = KERNEL_SIZE_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              pix_valid,
  output logic                   pix_ready,
  input  wire pix_t              pix_data,
  output logic                   mask_valid,
  input  wire logic              mask_ready,
  output mask_t                  mask_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int MW = $clog2(MAX_HEIGHT);
  localparam int NCELL = 4;

  cfg_t     cfg;
  reg_idx_t idx;
  logic     en;

  ctl_t          c_ctl [NCELL+1];
  logic [WW-1:0] c_w   [NCELL+1];
  logic [HW-1:0] c_h   [NCELL+1];

  logic [MW-1:0] mrow;
  logic [CW-1:0] mcol;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.diff_threshold   <= 8'd30;
      cfg.band_center_row  <= -13'sd1;
      cfg.band_margin_rows <= '0;
      cfg.frame_width      <= 12'd2048;
      cfg.frame_height     <= 13'd4096;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_THRESH: cfg.diff_threshold   <= pwdata[7:0];
        REG_CENTER: cfg.band_center_row  <= $signed(pwdata[12:0]);
        REG_MARGIN: cfg.band_margin_rows <= pwdata[11:0];
        REG_WIDTH:  cfg.frame_width      <= pwdata[11:0];
        REG_HEIGHT: cfg.frame_height     <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_THRESH: prdata = 32'(cfg.diff_threshold);
      REG_CENTER: prdata = 32'(cfg.band_center_row);
      REG_MARGIN: prdata = 32'(cfg.band_margin_rows);
      REG_WIDTH:  prdata = 32'(cfg.frame_width);
      REG_HEIGHT: prdata = 32'(cfg.frame_height);
      default:    prdata = '0;
    endcase
  end

  assign en        = !mask_valid || mask_ready;
  assign pix_ready = en;

  bdm_front #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .KERNEL_SIZE(KERNEL_SIZE)
  ) u_front (
    .clk(clk), .rst(rst), .en(en),
    .pix_take(pix_valid && pix_ready), .pix(pix_data), .cfg(cfg),
    .ctl(c_ctl[0]), .w(c_w[0]), .h(c_h[0])
  );

  // closing then opening: dilate, erode, erode, dilate
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    bdm_cell #(
      .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .KERNEL_SIZE(KERNEL_SIZE)
    ) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .dilate((i == 0) || (i == NCELL - 1)),
      .in_ctl(c_ctl[i]), .in_w(c_w[i]), .in_h(c_h[i]),
      .out_ctl(c_ctl[i+1]), .out_w(c_w[i+1]), .out_h(c_h[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mrow <= '0;
      mcol <= '0;
    end else if (mask_valid && mask_ready) begin
      if (c_ctl[NCELL].last) begin
        mrow <= '0;
        mcol <= '0;
      end else if (32'(mcol) + 1 == 32'(c_w[NCELL])) begin
        mcol <= '0;
        mrow <= mrow + MW'(1);
      end else begin
        mcol <= mcol + CW'(1);
      end
    end
  end

  assign mask_valid           = c_ctl[NCELL].strobe && c_ctl[NCELL].act;
  assign mask_data.foreground = c_ctl[NCELL].bit_v;
  assign mask_data.mask_col   = 11'(mcol);
  assign mask_data.mask_row   = 12'(mrow);
  assign mask_data.frame_last = c_ctl[NCELL].last && (c_h[NCELL] != '0);

endmodule

`default_nettype wire
